[rtl/dtk_pkg.sv]
// ============================================================================
// dtk_pkg - shared types and codes for the dual top-k tracker
// Slot layout, field widths and list-unit operation codes.
// ============================================================================
package dtk_pkg;

    localparam int DEPTH_DEFAULT = 10;
    localparam int ID_W          = 16;
    localparam int KEY_W         = 32;
    localparam int RANK_W        = 6;

    // One stored list entry; key is ordered ascending (smaller is better).
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } slot_t;

    // List unit operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
    localparam logic [OP_W-1:0] OP_FILL   = 3'd1;
    localparam logic [OP_W-1:0] OP_SORT   = 3'd2;
    localparam logic [OP_W-1:0] OP_RIPPLE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    // Map a signed mean to an ascending key and back (the map is its own inverse).
    function automatic logic [KEY_W-1:0] mean_to_key(input logic [KEY_W-1:0] m);
        mean_to_key = {m[KEY_W-1], ~m[KEY_W-2:0]};
    endfunction

endpackage

[rtl/dtk_list.sv]
// ============================================================================
// dtk_list - one ranked list with a single compare unit
// Memory-backed list; a small sequencer runs bubble passes and ripple inserts.
// ============================================================================
module dtk_list #(
    parameter int DEPTH = dtk_pkg::DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [dtk_pkg::OP_W-1:0] op,
    input  logic [AW-1:0]            addr,
    input  dtk_pkg::slot_t           in_slot,
    output logic                     busy,
    output dtk_pkg::slot_t           rd_slot
);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_SORT_LOAD  = 3'd1;
    localparam logic [2:0] S_SORT_STEP  = 3'd2;
    localparam logic [2:0] S_SORT_FLUSH = 3'd3;
    localparam logic [2:0] S_RIP_STEP   = 3'd4;

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    dtk_pkg::slot_t mem [DEPTH];

    logic [2:0]     state_reg, state_next;
    logic [AW-1:0]  idx_reg, idx_next;
    dtk_pkg::slot_t carry_reg, carry_next;
    logic           moved_reg, moved_next;
    dtk_pkg::slot_t rd_data_reg;

    logic                 we, re;
    logic [AW-1:0]        wa, ra;
    dtk_pkg::slot_t       wd;
    logic [dtk_pkg::KEY_W-1:0] cmp_a, cmp_b;
    logic                 cmp_lt, cmp_eq;

    // Shared comparator: sort asks "next below carry", ripple asks "carry below stored".
    always_comb begin
        if (state_reg == S_RIP_STEP) begin
            cmp_a = carry_reg.key;
            cmp_b = rd_data_reg.key;
        end else begin
            cmp_a = rd_data_reg.key;
            cmp_b = carry_reg.key;
        end
        cmp_lt = cmp_a < cmp_b;
        cmp_eq = cmp_a == cmp_b;
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        carry_next = carry_reg;
        moved_next = moved_reg;
        we         = 1'b0;
        wa         = addr;
        wd         = in_slot;
        re         = 1'b0;
        ra         = addr;
        unique case (state_reg)
            S_IDLE: begin
                unique case (op)
                    dtk_pkg::OP_FILL: begin
                        we = 1'b1;
                    end
                    dtk_pkg::OP_READ: begin
                        re = 1'b1;
                    end
                    dtk_pkg::OP_SORT: begin
                        if (DEPTH > 1) begin
                            re         = 1'b1;
                            ra         = '0;
                            state_next = S_SORT_LOAD;
                        end
                    end
                    dtk_pkg::OP_RIPPLE: begin
                        re         = 1'b1;
                        ra         = '0;
                        idx_next   = '0;
                        carry_next = in_slot;
                        state_next = S_RIP_STEP;
                    end
                    default: ;
                endcase
            end
            S_SORT_LOAD: begin
                carry_next = rd_data_reg;
                moved_next = 1'b0;
                re         = 1'b1;
                ra         = AW'(1);
                idx_next   = AW'(1);
                state_next = S_SORT_STEP;
            end
            S_SORT_STEP: begin
                we = 1'b1;
                wa = idx_reg - AW'(1);
                if (cmp_lt) begin
                    wd         = rd_data_reg;
                    moved_next = 1'b1;
                end else begin
                    wd         = carry_reg;
                    carry_next = rd_data_reg;
                end
                if (idx_reg == LAST_IDX) begin
                    state_next = S_SORT_FLUSH;
                end else begin
                    re       = 1'b1;
                    ra       = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_SORT_FLUSH: begin
                we = 1'b1;
                wa = LAST_IDX;
                wd = carry_reg;
                if (moved_reg) begin
                    re         = 1'b1;
                    ra         = '0;
                    state_next = S_SORT_LOAD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_RIP_STEP: begin
                if (cmp_lt) begin
                    we         = 1'b1;
                    wa         = idx_reg;
                    wd         = carry_reg;
                    carry_next = rd_data_reg;
                end
                if (cmp_eq || idx_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end else begin
                    re       = 1'b1;
                    ra       = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            moved_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            moved_reg <= moved_next;
        end
        idx_reg   <= idx_next;
        carry_reg <= carry_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            rd_data_reg <= mem[ra];
        end
    end

    assign busy    = state_reg != S_IDLE;
    assign rd_slot = rd_data_reg;

`ifndef SYNTHESIS
    a_no_op_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> op == dtk_pkg::OP_NONE)
        else $error("list op issued while sequencer busy");
    a_flush_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SORT_STEP && idx_reg == LAST_IDX) |=> state_reg == S_SORT_FLUSH)
        else $error("sort pass did not flush its carry");
    a_load_after_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SORT_FLUSH && moved_reg) |=> state_reg == S_SORT_LOAD)
        else $error("moved pass did not start another pass");
`endif

endmodule

[rtl/dual_top_k_tracker_core.sv]
// ============================================================================
// dual_top_k_tracker_core - dual top-k list tracker
// Keeps the LIST_DEPTH largest means and smallest spreads; dumps on last beat.
// ============================================================================
// Each input beat carries an id, a signed Q16.16 mean and an unsigned Q16.16
// spread; tlast marks the final entry of a set. The first LIST_DEPTH beats
// are stored in arrival order without holding off the next beat; the
// LIST_DEPTH-th beat also triggers a stable bubble sort of both lists, which
// holds off the next beat until it is done. Every later beat ripples down
// both lists from rank 0, stopping early on an equal key. Each list lives in
// a memory with one read and one write port and a single key comparator
// stepped by a small sequencer; the two lists run side by side. After a tlast
// beat the block emits LIST_DEPTH rank rows, each read and then presented
// until taken, with tuser flagging ranks that hold a received entry (other
// ranks read as zero), then clears its fill count. s_tready is low while a
// beat is being worked on or the dump is running.
module dual_top_k_tracker_core #(
    parameter int LIST_DEPTH = dtk_pkg::DEPTH_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // entry_id[15:0], mean_value[47:16], spread_value[79:48]
    input  logic         s_tlast,   // final_entry
    output logic         m_tvalid,
    input  logic         m_tready,
    // rank[5:0], best_mean_id[21:6], best_mean_value[53:22], best_spread_id[69:54],
    // best_spread_value[101:70], zero pad [103:102]
    output logic [103:0] m_tdata,
    output logic         m_tuser,   // row_valid
    output logic         m_tlast    // last_row
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    localparam logic [2:0] T_IDLE     = 3'd0;
    localparam logic [2:0] T_SORT     = 3'd1;
    localparam logic [2:0] T_WORK     = 3'd2;
    localparam logic [2:0] T_DUMP_RD  = 3'd3;
    localparam logic [2:0] T_DUMP_OUT = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] rank_reg, rank_next;
    logic          final_reg, final_next;

    logic [dtk_pkg::OP_W-1:0] lst_op;
    logic [AW-1:0]            lst_addr;
    dtk_pkg::slot_t           mean_in, spread_in, mean_rd, spread_rd;
    logic                     mean_busy, spread_busy;

    logic s_beat, m_beat, row_valid, last_row;

    assign s_tready = state_reg == T_IDLE;
    assign m_tvalid = state_reg == T_DUMP_OUT;
    assign s_beat   = s_tvalid && s_tready;
    assign m_beat   = m_tvalid && m_tready;

    // Mean is stored as an ascending key so both lists use the same list unit design.
    assign mean_in.id     = s_tdata[15:0];
    assign mean_in.key    = dtk_pkg::mean_to_key(s_tdata[47:16]);
    assign spread_in.id   = s_tdata[15:0];
    assign spread_in.key  = s_tdata[79:48];

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        rank_next  = rank_reg;
        final_next = final_reg;
        lst_op     = dtk_pkg::OP_NONE;
        lst_addr   = fill_reg[AW-1:0];
        unique case (state_reg)
            T_IDLE: begin
                if (s_beat) begin
                    final_next = s_tlast;
                    rank_next  = '0;
                    if (fill_reg < CW'(LIST_DEPTH)) begin
                        // Store in arrival order; sort once the list is full.
                        lst_op    = dtk_pkg::OP_FILL;
                        fill_next = fill_reg + CW'(1);
                        if (fill_reg == CW'(LIST_DEPTH - 1)) begin
                            state_next = T_SORT;
                        end else if (s_tlast) begin
                            state_next = T_DUMP_RD;
                        end
                    end else begin
                        lst_op     = dtk_pkg::OP_RIPPLE;
                        state_next = T_WORK;
                    end
                end
            end
            T_SORT: begin
                lst_op     = dtk_pkg::OP_SORT;
                state_next = T_WORK;
            end
            T_WORK: begin
                // Hold until both sequencers are back to idle.
                if (!mean_busy && !spread_busy) begin
                    state_next = final_reg ? T_DUMP_RD : T_IDLE;
                end
            end
            T_DUMP_RD: begin
                lst_op     = dtk_pkg::OP_READ;
                lst_addr   = rank_reg;
                state_next = T_DUMP_OUT;
            end
            T_DUMP_OUT: begin
                if (m_beat) begin
                    if (last_row) begin
                        fill_next  = '0;
                        final_next = 1'b0;
                        state_next = T_IDLE;
                    end else begin
                        rank_next  = rank_reg + AW'(1);
                        state_next = T_DUMP_RD;
                    end
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
            fill_reg  <= '0;
            rank_reg  <= '0;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            rank_reg  <= rank_next;
            final_reg <= final_next;
        end
    end

    dtk_list #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_mean_list (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (lst_op),
        .addr    (lst_addr),
        .in_slot (mean_in),
        .busy    (mean_busy),
        .rd_slot (mean_rd)
    );

    dtk_list #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_spread_list (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (lst_op),
        .addr    (lst_addr),
        .in_slot (spread_in),
        .busy    (spread_busy),
        .rd_slot (spread_rd)
    );

    // Output row: ranks not below the fill count hold no entry of this set and read as zero.
    assign row_valid = CW'(rank_reg) < fill_reg;
    assign last_row  = rank_reg == AW'(LIST_DEPTH - 1);

    always_comb begin
        m_tdata        = '0;
        m_tdata[5:0]   = dtk_pkg::RANK_W'(rank_reg);
        if (row_valid) begin
            m_tdata[21:6]   = mean_rd.id;
            m_tdata[53:22]  = dtk_pkg::mean_to_key(mean_rd.key);
            m_tdata[69:54]  = spread_rd.id;
            m_tdata[101:70] = spread_rd.key;
        end
    end

    assign m_tuser = row_valid;
    assign m_tlast = last_row;

`ifndef SYNTHESIS
    a_no_input_during_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while dump row pending");
    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(LIST_DEPTH))
        else $error("fill count beyond list depth");
    a_clear_after_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_beat && m_tlast) |=> (fill_reg == '0 && s_tready))
        else $error("state not cleared after last dump row");
    a_empty_row_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tdata[103:6] == '0)
        else $error("empty rank row carries data");
`endif

endmodule
